/* src/tcpq_pkg.sv */
// Shared constants, types and helpers for the three-class priority queue.
`timescale 1ns / 1ps
`default_nettype none

package tcpq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int DATA_WIDTH  = 32;
  localparam int NUM_CLASSES = 3;

  localparam int PAYLOAD_W = 32;
  localparam int CLASS_W   = 2;
  localparam int STATUS_W  = 3;
  localparam int TOTAL_W   = 6;
  localparam int ACTION_W  = 1;

  localparam int PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int MEM_DEPTH = NUM_CLASSES * QUEUE_DEPTH;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  localparam int IN_TUSER_W  = ACTION_W + CLASS_W;
  localparam int OUT_FIELD_W = PAYLOAD_W + CLASS_W + TOTAL_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  localparam logic [ACTION_W-1:0] ACT_PUSH = 1'b0;
  localparam logic [ACTION_W-1:0] ACT_POP  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_CLASS = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_STOPPED   = 3'd4;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = TOTAL_W'(MEM_DEPTH);

  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic [ADDR_W-1:0] addr;
  } ram_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                pop_ok;
    logic [CLASS_W-1:0]  cls;
    logic [TOTAL_W-1:0]  total;
  } result_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
    ptr_inc = (ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
  endfunction

  function automatic logic [ADDR_W-1:0] mem_addr(input int cls, input logic [PTR_W-1:0] ptr);
    mem_addr = ADDR_W'(cls * QUEUE_DEPTH) + ADDR_W'(ptr);
  endfunction

endpackage

`default_nettype wire

/* src/tcpq_ram.sv */
// Single-port synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module tcpq_ram #(
  parameter int DEPTH = 48,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[addr];
    end
  end

endmodule

`default_nettype wire

/* src/tcpq_ctrl.sv */
// Per-class head, tail and count registers with push and pop decisions.
`timescale 1ns / 1ps
`default_nettype none

module tcpq_ctrl
  import tcpq_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                accept,
  input  wire logic [ACTION_W-1:0] action,
  input  wire logic [CLASS_W-1:0]  cls,
  input  wire logic                stop,
  output ram_req_t                 req,
  output result_t                  res
);

  logic [PTR_W-1:0] heads      [NUM_CLASSES];
  logic [PTR_W-1:0] tails      [NUM_CLASSES];
  logic [CNT_W-1:0] counts     [NUM_CLASSES];
  logic [PTR_W-1:0] heads_next [NUM_CLASSES];
  logic [PTR_W-1:0] tails_next [NUM_CLASSES];
  logic [CNT_W-1:0] counts_next[NUM_CLASSES];
  ram_req_t         req_raw;
  logic             found;
  logic [TOTAL_W-1:0] sum;

  always_comb begin
    heads_next  = heads;
    tails_next  = tails;
    counts_next = counts;
    req_raw     = '0;
    res         = '0;
    res.status  = ST_OK;
    found       = 1'b0;
    sum         = '0;
    if (action == ACT_PUSH) begin
      if (int'(cls) >= NUM_CLASSES) begin
        res.status = ST_BAD_CLASS;
      end else begin
        for (int c = 0; c < NUM_CLASSES; c++) begin
          if (CLASS_W'(c) == cls) begin
            if (counts[c] == CNT_W'(QUEUE_DEPTH)) begin
              res.status = ST_FULL;
            end else begin
              req_raw.wr_en  = 1'b1;
              req_raw.addr   = mem_addr(c, tails[c]);
              tails_next[c]  = ptr_inc(tails[c]);
              counts_next[c] = counts[c] + 1'b1;
            end
          end
        end
      end
    end else if (stop) begin
      res.status = ST_STOPPED;
    end else begin
      res.status = ST_EMPTY;
      for (int c = 0; c < NUM_CLASSES; c++) begin
        if (!found && counts[c] != '0) begin
          found          = 1'b1;
          res.status     = ST_OK;
          res.pop_ok     = 1'b1;
          res.cls        = CLASS_W'(c);
          req_raw.rd_en  = 1'b1;
          req_raw.addr   = mem_addr(c, heads[c]);
          heads_next[c]  = ptr_inc(heads[c]);
          counts_next[c] = counts[c] - 1'b1;
        end
      end
    end
    for (int c = 0; c < NUM_CLASSES; c++) begin
      sum = sum + TOTAL_W'(counts_next[c]);
    end
    res.total = sum;
    req       = req_raw;
    req.wr_en = req_raw.wr_en & accept;
    req.rd_en = req_raw.rd_en & accept;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        heads[c]  <= '0;
        tails[c]  <= '0;
        counts[c] <= '0;
      end
    end else if (accept) begin
      heads  <= heads_next;
      tails  <= tails_next;
      counts <= counts_next;
    end
  end

endmodule

`default_nettype wire

/* src/three_class_strict_priority_queue_unit.sv */
// Top level of the three-class strict priority queue.
//
// Requests arrive on the s_ channel: s_tuser carries the action (push or pop) and the
// priority class, s_tdata the payload word. Each request yields exactly one result on
// the m_ channel: m_tuser carries the status, m_tdata the popped word, its class and
// the total number of words held after the request.
// Payload words live in a single-port RAM of three classes by sixteen entries; its read
// data is registered, so a result passes through the pending stage and then the output
// register before it appears on m_tvalid.
// Throughput is one request per cycle while m_tready stays high: one request sits in
// the pending stage waiting for RAM read data while the output register holds the
// previous result.
// When m_tready is low the output register holds its result, the pending stage fills
// and s_tready drops until the output drains.
// cfg_wr_en writes the stop flag; while set, pops return status stopped.
// rst (synchronous, active high) empties every class and clears the stop flag; the
// RAM needs no clearing pass and the block takes requests in the cycle after reset.
`timescale 1ns / 1ps
`default_nettype none

module three_class_strict_priority_queue_unit
  import tcpq_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [PAYLOAD_W-1:0]   s_tdata,   // payload_in
  input  wire logic [IN_TUSER_W-1:0]  s_tuser,   // action, priority_class
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic      [OUT_TDATA_W-1:0] m_tdata,   // payload_out, popped_class, total_held
  output logic      [STATUS_W-1:0]    m_tuser,   // status
  input  wire logic                   cfg_wr_en,
  input  wire logic                   cfg_wr_data
);

  logic                  stop;
  logic                  accept;
  logic                  move;
  logic                  pend_valid;
  result_t               pend_res;
  result_t               res;
  ram_req_t              req;
  logic [DATA_WIDTH-1:0] rd_data;
  logic [STATUS_W-1:0]   out_status;
  logic [PAYLOAD_W-1:0]  out_payload;
  logic [CLASS_W-1:0]    out_cls;
  logic [TOTAL_W-1:0]    out_total;

  assign move     = pend_valid && (!m_tvalid || m_tready);
  assign s_tready = !pend_valid || move;
  assign accept   = s_tvalid && s_tready;

  tcpq_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .action (s_tuser[ACTION_W-1:0]),
    .cls    (s_tuser[IN_TUSER_W-1:ACTION_W]),
    .stop   (stop),
    .req    (req),
    .res    (res)
  );

  tcpq_ram #(
    .DEPTH (MEM_DEPTH),
    .WIDTH (DATA_WIDTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (req.wr_en),
    .rd_en   (req.rd_en),
    .addr    (req.addr),
    .wr_data (DATA_WIDTH'(s_tdata)),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stop       <= 1'b0;
      pend_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        stop <= cfg_wr_data;
      end
      if (accept) begin
        pend_valid <= 1'b1;
      end else if (move) begin
        pend_valid <= 1'b0;
      end
      if (move) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_res <= res;
    end
    if (move) begin
      out_status  <= pend_res.status;
      out_payload <= pend_res.pop_ok ? PAYLOAD_W'(rd_data) : '0;
      out_cls     <= pend_res.cls;
      out_total   <= pend_res.total;
    end
  end

  assign m_tdata = OUT_TDATA_W'({out_total, out_cls, out_payload});
  assign m_tuser = out_status;

endmodule

`default_nettype wire

/* src/tcpq_checker.sv */
// Port-level checks for the three-class priority queue, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module tcpq_checker
  import tcpq_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   m_tvalid,
  input wire logic                   m_tready,
  input wire logic [OUT_TDATA_W-1:0] m_tdata,
  input wire logic [STATUS_W-1:0]    m_tuser
);

  a_reset_clears_output: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_failed_result_is_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != ST_OK |-> m_tdata[PAYLOAD_W+CLASS_W-1:0] == '0)
    else $error("non-ok result carries payload or class");

  a_total_in_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[OUT_FIELD_W-1:PAYLOAD_W+CLASS_W] <= TOTAL_MAX
                 && m_tuser <= ST_STOPPED)
    else $error("total held or status out of range");

endmodule

bind three_class_strict_priority_queue_unit tcpq_checker u_tcpq_checker (.*);

`default_nettype wire

/* sim/tcpq_checker.sv */
// Scoreboard that predicts and checks every result of the three-class priority queue.
`timescale 1ns / 1ps

module tcpq_scoreboard
  import tcpq_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [PAYLOAD_W-1:0]   s_tdata,
  input  logic [IN_TUSER_W-1:0]  s_tuser,
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic [STATUS_W-1:0]    m_tuser,
  input  logic                   cfg_wr_en,
  input  logic                   cfg_wr_data,
  output int                     fail_count,
  output int                     awaiting,
  output int                     results_seen
);

  typedef struct {
    logic [STATUS_W-1:0]  status;
    logic [PAYLOAD_W-1:0] word;
    logic [CLASS_W-1:0]   cls;
    logic [TOTAL_W-1:0]   total;
  } queue_reply_t;

  logic [DATA_WIDTH-1:0] slots [NUM_CLASSES][QUEUE_DEPTH];
  int                    head_idx [NUM_CLASSES];
  int                    tail_idx [NUM_CLASSES];
  int                    fill [NUM_CLASSES];
  logic                  pops_stopped;
  queue_reply_t          awaited_replies [$];

  function automatic queue_reply_t serve_request(input logic act,
                                                 input logic [CLASS_W-1:0] cls,
                                                 input logic [PAYLOAD_W-1:0] word);
    queue_reply_t r;
    int           held;
    bit           found;
    r.status = ST_OK;
    r.word   = '0;
    r.cls    = '0;
    held     = 0;
    found    = 1'b0;
    if (act == ACT_PUSH) begin
      if (cls >= NUM_CLASSES) begin
        r.status = ST_BAD_CLASS;
      end else if (fill[cls] >= QUEUE_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        slots[cls][tail_idx[cls]] = DATA_WIDTH'(word);
        tail_idx[cls] = (tail_idx[cls] + 1) % QUEUE_DEPTH;
        fill[cls]++;
      end
    end else if (pops_stopped) begin
      r.status = ST_STOPPED;
    end else begin
      r.status = ST_EMPTY;
      for (int c = 0; c < NUM_CLASSES; c++) begin
        if (!found && fill[c] > 0) begin
          found = 1'b1;
          r.word = PAYLOAD_W'(slots[c][head_idx[c]]);
          head_idx[c] = (head_idx[c] + 1) % QUEUE_DEPTH;
          fill[c]--;
          r.cls = CLASS_W'(c);
          r.status = ST_OK;
        end
      end
    end
    for (int c = 0; c < NUM_CLASSES; c++) held += fill[c];
    r.total = TOTAL_W'(held);
    return r;
  endfunction

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    queue_reply_t want;
    if (rst) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        head_idx[c] = 0;
        tail_idx[c] = 0;
        fill[c]     = 0;
      end
      pops_stopped = 1'b0;
      awaited_replies.delete();
      fail_count   = 0;
      results_seen = 0;
    end else begin
      if (cfg_wr_en) pops_stopped = cfg_wr_data;
      if (s_tvalid && s_tready) begin
        awaited_replies.insert(awaited_replies.size(),
                               serve_request(s_tuser[0], s_tuser[ACTION_W +: CLASS_W],
                                             s_tdata));
      end
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (awaited_replies.size() == 0) begin
          $error("unexpected result: status 0x%0h, data 0x%0h", m_tuser, m_tdata);
          fail_count++;
        end else begin
          want = awaited_replies[0];
          awaited_replies.delete(0);
          check_field("status", want.status, m_tuser);
          check_field("payload_out", want.word, m_tdata[0 +: PAYLOAD_W]);
          check_field("popped_class", want.cls, m_tdata[PAYLOAD_W +: CLASS_W]);
          check_field("total_held", want.total, m_tdata[PAYLOAD_W + CLASS_W +: TOTAL_W]);
        end
      end
    end
    awaiting = awaited_replies.size();
  end

endmodule

/* sim/tb.sv */
// Stimulus and verdict for the three-class priority queue, with the scoreboard beside it.
`timescale 1ns / 1ps

module tb;
  import tcpq_pkg::*;

  localparam int QUIET_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 6;
  localparam int BURST_FILL    = 0;
  localparam int BURST_DRAIN   = 1;
  localparam int BURST_MIXED   = 2;
  localparam int BURST_FOCUS   = 3;
  localparam logic [CLASS_W-1:0] BAD_CLASS = CLASS_W'(NUM_CLASSES);

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [PAYLOAD_W-1:0]   s_tdata;
  logic [IN_TUSER_W-1:0]  s_tuser;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [STATUS_W-1:0]    m_tuser;
  logic                   cfg_wr_en;
  logic                   cfg_wr_data;

  int fail_count;
  int awaiting;
  int results_seen;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int requests_sent  = 0;
  int stop_writes    = 0;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  three_class_strict_priority_queue_unit dut (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  tcpq_scoreboard u_scoreboard (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .fail_count   (fail_count),
    .awaiting     (awaiting),
    .results_seen (results_seen)
  );

  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("[three_class_strict_priority_queue_unit] ERROR");
    $finish;
  end

  task automatic send_request(input logic act, input logic [CLASS_W-1:0] cls,
                              input logic [PAYLOAD_W-1:0] word);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= {cls, act};
    s_tdata  <= word;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    requests_sent++;
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (awaiting != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_stop(input logic value);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    stop_writes++;
  endtask

  task automatic run_bursts(input int count);
    int                   left;
    int                   mode;
    int                   len;
    int                   push_pct;
    logic [CLASS_W-1:0]   focus;
    logic                 act;
    logic [CLASS_W-1:0]   cls;
    logic [PAYLOAD_W-1:0] word;
    left = count;
    while (left > 0) begin
      mode  = $urandom_range(3);
      len   = $urandom_range(60, 1);
      focus = CLASS_W'($urandom_range(NUM_CLASSES - 1));
      if (len > left) len = left;
      left -= len;
      case (mode)
        BURST_FILL:  push_pct = 90;
        BURST_DRAIN: push_pct = 10;
        BURST_FOCUS: push_pct = 80;
        BURST_MIXED: push_pct = 50;
        default:     push_pct = 50;
      endcase
      repeat (len) begin
        act = ($urandom_range(99) < push_pct) ? ACT_PUSH : ACT_POP;
        if ($urandom_range(99) < 5) begin
          cls = BAD_CLASS;
        end else if (mode == BURST_FOCUS && $urandom_range(99) < 80) begin
          cls = focus;
        end else begin
          cls = CLASS_W'($urandom_range(NUM_CLASSES - 1));
        end
        case ($urandom_range(9))
          0:       word = '0;
          1:       word = '1;
          default: word = $urandom;
        endcase
        send_request(act, cls, word);
      end
    end
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    run_bursts(200);
    write_stop(1'b1);
    run_bursts(25);
    write_stop(1'b0);
    run_bursts(185);
  endtask

  initial begin
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tuser     = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_request(ACT_POP, '0, '0);
    send_request(ACT_PUSH, BAD_CLASS, '1);
    send_request(ACT_PUSH, 2'd2, '1);
    send_request(ACT_PUSH, 2'd1, 32'h0000_0001);
    send_request(ACT_PUSH, 2'd0, '0);
    send_request(ACT_PUSH, 2'd0, 32'h8000_0000);
    send_request(ACT_POP, 2'd3, '1);
    send_request(ACT_POP, '0, '0);
    send_request(ACT_POP, '0, '0);
    write_stop(1'b1);
    send_request(ACT_POP, '0, '0);
    send_request(ACT_PUSH, 2'd1, 32'hA5A5_5A5A);
    send_request(ACT_POP, '0, '0);
    write_stop(1'b0);
    send_request(ACT_POP, '0, '0);
    send_request(ACT_POP, '0, '0);
    send_request(ACT_POP, '0, '0);
    write_stop(1'b1);
    send_request(ACT_POP, '0, '0);
    write_stop(1'b0);
    send_request(ACT_PUSH, BAD_CLASS, '0);

    run_phase(0, 0);
    run_phase(71, 0);
    run_phase(0, 71);
    run_phase(20, 20);

    settle();
    $display("Sent %0d requests over four pacing phases, %0d stop flag writes,",
             requests_sent, stop_writes);
    $display("and checked %0d results against the prediction.", results_seen);
    if (fail_count == 0) begin
      $display("[three_class_strict_priority_queue_unit] OK");
    end else begin
      $display("[three_class_strict_priority_queue_unit] ERROR");
    end
    $finish;
  end

endmodule
